/* sv/cpg_pkg.sv */
// Package: field widths, register map and default sizes for the constellation pair generator
package cpg_pkg;

    localparam int TIME_W = 32;
    localparam int FREQ_W = 10;
    localparam int GAP_W = 6;
    localparam int ZONE_W = 4;
    localparam int LOOKBACK_W = 7;
    localparam int CELL_W = TIME_W + FREQ_W;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [0:0] REG_ANCHOR_GAP = 1'b0;
    localparam logic [0:0] REG_ZONE_SIZE = 1'b1;

    localparam logic [GAP_W-1:0] ANCHOR_GAP_RESET = 6'd8;
    localparam logic [ZONE_W-1:0] ZONE_SIZE_RESET = 4'd5;

    localparam int HISTORY_DEPTH_DEFAULT = 64;
    localparam int MAX_ZONE_DEFAULT = 8;

endpackage

/* sv/cpg_if.sv */
// Interfaces: peak cell input channel and pair record output channel
interface cpg_cell_if;
    logic                        valid;
    logic                        ready;
    logic [cpg_pkg::TIME_W-1:0]  cell_time;
    logic [cpg_pkg::FREQ_W-1:0]  cell_freq;

    modport source (output valid, output cell_time, output cell_freq, input ready);
    modport sink (input valid, input cell_time, input cell_freq, output ready);
endinterface

interface cpg_pair_if;
    logic                        valid;
    logic                        ready;
    logic [cpg_pkg::FREQ_W-1:0]  anchor_freq;
    logic [cpg_pkg::FREQ_W-1:0]  point_freq;
    logic [cpg_pkg::TIME_W-1:0]  time_delta;
    logic [cpg_pkg::TIME_W-1:0]  anchor_time;
    logic                        last_in_zone;

    modport source (output valid, output anchor_freq, output point_freq, output time_delta,
                    output anchor_time, output last_in_zone, input ready);
    modport sink (input valid, input anchor_freq, input point_freq, input time_delta,
                  input anchor_time, input last_in_zone, output ready);
endinterface

/* sv/constellation_pair_generator.sv */
// Top level: anchor and target zone pairing over a ring of recent peak cells
// A cell that closes a zone passes ANCHOR, CAPTURE and EMIT before its first record is
// registered; each further record takes POINT and EMIT through the single history read
// port, EMIT waits while the output word is full, and no cell is accepted outside IDLE.
// Reset: asynchronous, active low; clears ring pointer, fill count, sequencer and
// output word, and loads anchor_gap 8 and zone_size 5. History contents are not cleared.
module constellation_pair_generator #(
    parameter int HISTORY_DEPTH = cpg_pkg::HISTORY_DEPTH_DEFAULT,
    parameter int MAX_ZONE = cpg_pkg::MAX_ZONE_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cpg_pkg::ADDR_W-1:0]  paddr,
    input  logic [cpg_pkg::DATA_W-1:0]  pwdata,
    output logic [cpg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    cpg_cell_if.sink                    peak,
    cpg_pair_if.source                  pair
);

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int SEEN_W = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W = (SLOT_W + 1 > cpg_pkg::LOOKBACK_W) ? SLOT_W + 1
                                                              : cpg_pkg::LOOKBACK_W;

    localparam logic [0:0] REG_SEL_GAP = cpg_pkg::REG_ANCHOR_GAP;
    localparam logic [0:0] REG_SEL_ZONE = cpg_pkg::REG_ZONE_SIZE;

    typedef enum logic [2:0] {
        IDLE,
        ANCHOR,
        CAPTURE,
        POINT,
        EMIT
    } state_t;

    function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] newest,
                                                    input logic [SLOT_W-1:0] back);
        logic [SLOT_W:0] sum;
        sum = {1'b0, newest} + (SLOT_W+1)'(HISTORY_DEPTH) - {1'b0, back};
        if (sum >= (SLOT_W+1)'(HISTORY_DEPTH))
        begin
            sum = sum - (SLOT_W+1)'(HISTORY_DEPTH);
        end
        return sum[SLOT_W-1:0];
    endfunction

    logic [cpg_pkg::GAP_W-1:0]   anchor_gap_reg;
    logic [cpg_pkg::ZONE_W-1:0]  zone_size_reg;

    logic [cpg_pkg::CELL_W-1:0]  history [HISTORY_DEPTH];
    logic [cpg_pkg::CELL_W-1:0]  rdata_reg;

    state_t                      state_reg, state_next;
    logic [SLOT_W-1:0]           write_slot_reg, write_slot_next;
    logic [SEEN_W-1:0]           cells_seen_reg, cells_seen_next;
    logic [SLOT_W-1:0]           newest_reg, newest_next;
    logic [cpg_pkg::ZONE_W-1:0]  zs_reg, zs_next;
    logic [CMP_W-1:0]            lookback_reg, lookback_next;
    logic [cpg_pkg::ZONE_W-1:0]  z_reg, z_next;
    logic [cpg_pkg::TIME_W-1:0]  a_time_reg, a_time_next;
    logic [cpg_pkg::FREQ_W-1:0]  a_freq_reg, a_freq_next;

    logic                        out_valid_reg, out_valid_next;
    logic [cpg_pkg::FREQ_W-1:0]  out_afreq_reg, out_afreq_next;
    logic [cpg_pkg::FREQ_W-1:0]  out_pfreq_reg, out_pfreq_next;
    logic [cpg_pkg::TIME_W-1:0]  out_delta_reg, out_delta_next;
    logic [cpg_pkg::TIME_W-1:0]  out_atime_reg, out_atime_next;
    logic                        out_last_reg, out_last_next;

    logic                        accept;
    logic                        cfg_write;
    logic [cpg_pkg::ZONE_W-1:0]  zs_clamped;
    logic [CMP_W-1:0]            lookback_c;
    logic                        out_free;
    logic                        rd_en;
    logic [SLOT_W-1:0]           rd_addr;
    logic [cpg_pkg::TIME_W-1:0]  rd_time;
    logic [cpg_pkg::FREQ_W-1:0]  rd_freq;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_SEL_GAP:  prdata = cpg_pkg::DATA_W'(anchor_gap_reg);
            REG_SEL_ZONE: prdata = cpg_pkg::DATA_W'(zone_size_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_gap_reg <= cpg_pkg::ANCHOR_GAP_RESET;
            zone_size_reg <= cpg_pkg::ZONE_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_SEL_GAP)
            begin
                anchor_gap_reg <= pwdata[cpg_pkg::GAP_W-1:0];
            end
            else
            begin
                zone_size_reg <= pwdata[cpg_pkg::ZONE_W-1:0];
            end
        end
    end

    assign peak.ready = (state_reg == IDLE);
    assign accept = peak.valid && peak.ready;
    assign out_free = !out_valid_reg || pair.ready;

    assign rd_time = rdata_reg[cpg_pkg::CELL_W-1:cpg_pkg::FREQ_W];
    assign rd_freq = rdata_reg[cpg_pkg::FREQ_W-1:0];

    always_comb
    begin
        if (int'(zone_size_reg) > MAX_ZONE)
        begin
            zs_clamped = cpg_pkg::ZONE_W'(MAX_ZONE);
        end
        else
        begin
            zs_clamped = zone_size_reg;
        end
        lookback_c = CMP_W'(anchor_gap_reg) + CMP_W'(zs_clamped) - CMP_W'(1);
    end

    always_comb
    begin
        rd_en = 1'b0;
        rd_addr = slot_back(newest_reg, SLOT_W'(zs_reg - z_reg - cpg_pkg::ZONE_W'(1)));
        case (state_reg)
            ANCHOR:
            begin
                rd_en = 1'b1;
                rd_addr = slot_back(newest_reg, lookback_reg[SLOT_W-1:0]);
            end
            CAPTURE, POINT:
            begin
                rd_en = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            history[write_slot_reg] <= {peak.cell_time, peak.cell_freq};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= history[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        write_slot_next = write_slot_reg;
        cells_seen_next = cells_seen_reg;
        newest_next = newest_reg;
        zs_next = zs_reg;
        lookback_next = lookback_reg;
        z_next = z_reg;
        a_time_next = a_time_reg;
        a_freq_next = a_freq_reg;
        out_valid_next = out_valid_reg && !pair.ready;
        out_afreq_next = out_afreq_reg;
        out_pfreq_next = out_pfreq_reg;
        out_delta_next = out_delta_reg;
        out_atime_next = out_atime_reg;
        out_last_next = out_last_reg;
        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    newest_next = write_slot_reg;
                    if (write_slot_reg == SLOT_W'(HISTORY_DEPTH - 1))
                    begin
                        write_slot_next = '0;
                    end
                    else
                    begin
                        write_slot_next = write_slot_reg + SLOT_W'(1);
                    end
                    if (cells_seen_reg < SEEN_W'(HISTORY_DEPTH))
                    begin
                        cells_seen_next = cells_seen_reg + SEEN_W'(1);
                    end
                    zs_next = zs_clamped;
                    lookback_next = lookback_c;
                    z_next = '0;
                    if ((zs_clamped != '0) && (lookback_c < CMP_W'(HISTORY_DEPTH))
                        && (lookback_c < CMP_W'(cells_seen_next)))
                    begin
                        state_next = ANCHOR;
                    end
                end
            end
            ANCHOR:
            begin
                state_next = CAPTURE;
            end
            CAPTURE:
            begin
                a_time_next = rd_time;
                a_freq_next = rd_freq;
                state_next = EMIT;
            end
            POINT:
            begin
                state_next = EMIT;
            end
            EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_afreq_next = a_freq_reg;
                    out_pfreq_next = rd_freq;
                    out_delta_next = rd_time - a_time_reg;
                    out_atime_next = a_time_reg;
                    out_last_next = (z_reg + cpg_pkg::ZONE_W'(1) == zs_reg);
                    z_next = z_reg + cpg_pkg::ZONE_W'(1);
                    if (z_reg + cpg_pkg::ZONE_W'(1) == zs_reg)
                    begin
                        state_next = IDLE;
                    end
                    else
                    begin
                        state_next = POINT;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            write_slot_reg <= '0;
            cells_seen_reg <= '0;
            newest_reg <= '0;
            zs_reg <= '0;
            lookback_reg <= '0;
            z_reg <= '0;
            a_time_reg <= '0;
            a_freq_reg <= '0;
            out_valid_reg <= 1'b0;
            out_afreq_reg <= '0;
            out_pfreq_reg <= '0;
            out_delta_reg <= '0;
            out_atime_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            write_slot_reg <= write_slot_next;
            cells_seen_reg <= cells_seen_next;
            newest_reg <= newest_next;
            zs_reg <= zs_next;
            lookback_reg <= lookback_next;
            z_reg <= z_next;
            a_time_reg <= a_time_next;
            a_freq_reg <= a_freq_next;
            out_valid_reg <= out_valid_next;
            out_afreq_reg <= out_afreq_next;
            out_pfreq_reg <= out_pfreq_next;
            out_delta_reg <= out_delta_next;
            out_atime_reg <= out_atime_next;
            out_last_reg <= out_last_next;
        end
    end

    assign pair.valid = out_valid_reg;
    assign pair.anchor_freq = out_afreq_reg;
    assign pair.point_freq = out_pfreq_reg;
    assign pair.time_delta = out_delta_reg;
    assign pair.anchor_time = out_atime_reg;
    assign pair.last_in_zone = out_last_reg;

    property p_ready_only_idle;
        @(posedge clk) disable iff (!rst_n)
        peak.ready |-> (state_reg == IDLE);
    endproperty
    assert property (p_ready_only_idle)
        else $error("peak channel ready outside idle");

    property p_zone_counter_bound;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == POINT || state_reg == EMIT) |-> (z_reg < zs_reg);
    endproperty
    assert property (p_zone_counter_bound)
        else $error("zone counter ran past zone size");

    property p_more_records_pending;
        @(posedge clk) disable iff (!rst_n)
        (pair.valid && !pair.last_in_zone) |-> (state_reg != IDLE);
    endproperty
    assert property (p_more_records_pending)
        else $error("sequencer idle before last word of zone");

endmodule

/* sim/constellation_pair_generator_tb.sv */
// Testbench: constellation pair generator against its own pairing predictor
`timescale 1ns / 1ps

module constellation_pair_generator_tb;

    localparam int RING_DEPTH = cpg_pkg::HISTORY_DEPTH_DEFAULT;
    localparam int ZONE_CAP = cpg_pkg::MAX_ZONE_DEFAULT;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [cpg_pkg::TIME_W-1:0] t;
        logic [cpg_pkg::FREQ_W-1:0] f;
    } peak_cell_t;

    typedef struct {
        logic [cpg_pkg::FREQ_W-1:0] anchor_freq;
        logic [cpg_pkg::FREQ_W-1:0] point_freq;
        logic [cpg_pkg::TIME_W-1:0] time_delta;
        logic [cpg_pkg::TIME_W-1:0] anchor_time;
        logic                       last_in_zone;
    } pair_rec_t;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [cpg_pkg::ADDR_W-1:0] paddr;
    logic [cpg_pkg::DATA_W-1:0] pwdata;
    logic [cpg_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    cpg_cell_if cell_ch ();
    cpg_pair_if pair_ch ();

    peak_cell_t                 peak_ring [RING_DEPTH];
    logic [5:0]                 ring_wr;
    int unsigned                ring_fill;
    logic [cpg_pkg::GAP_W-1:0]  gap_reg;
    logic [cpg_pkg::ZONE_W-1:0] zone_reg;
    pair_rec_t                  pending_pairs [$];

    logic [cpg_pkg::TIME_W-1:0] stream_time;
    logic                       idle_on;
    logic                       long_hold_req;
    int                         failures;
    int                         quiet_cycles;

    constellation_pair_generator uut (
        clk, rst_n, psel, penable, pwrite, paddr, pwdata, prdata, pready, cell_ch, pair_ch
    );

    always #1 clk = ~clk;

    function automatic void predict_pairs(input peak_cell_t c);
        int unsigned zs;
        int unsigned span;
        int unsigned z;
        logic [5:0]  newest;
        logic [5:0]  a_slot;
        logic [5:0]  p_slot;
        pair_rec_t   rec;
        newest = ring_wr;
        peak_ring[newest] = c;
        ring_wr = newest + 6'd1;
        if (ring_fill < RING_DEPTH)
            ring_fill++;
        zs = (zone_reg > ZONE_CAP) ? ZONE_CAP : zone_reg;
        if (zs == 0)
            return;
        span = gap_reg + zs - 1;
        if (span >= RING_DEPTH || span >= ring_fill)
            return;
        a_slot = newest - span[5:0];
        for (z = 0; z < zs; z++)
        begin
            p_slot = newest - 6'(zs - 1 - z);
            rec.anchor_freq = peak_ring[a_slot].f;
            rec.point_freq = peak_ring[p_slot].f;
            rec.time_delta = peak_ring[p_slot].t - peak_ring[a_slot].t;
            rec.anchor_time = peak_ring[a_slot].t;
            rec.last_in_zone = (z + 1 == zs);
            pending_pairs.push_back(rec);
        end
    endfunction

    function automatic peak_cell_t next_cell();
        peak_cell_t c;
        if ($urandom_range(0, 7) == 0)
            stream_time = $urandom;
        else
            stream_time = stream_time + $urandom_range(1, 60);
        c.t = stream_time;
        c.f = cpg_pkg::FREQ_W'($urandom_range(0, 1023));
        return c;
    endfunction

    task automatic send_cell(input peak_cell_t c);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            cell_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        cell_ch.valid <= 1'b1;
        cell_ch.cell_time <= c.t;
        cell_ch.cell_freq <= c.f;
        @(posedge clk);
        while (!cell_ch.ready)
            @(posedge clk);
        predict_pairs(c);
    endtask

    task automatic settle_block();
        cell_ch.valid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [cpg_pkg::DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == cpg_pkg::REG_ANCHOR_GAP)
            gap_reg = value[cpg_pkg::GAP_W-1:0];
        else
            zone_reg = value[cpg_pkg::ZONE_W-1:0];
    endtask

    task automatic apply_config(input int gap, input int zone);
        logic [cpg_pkg::DATA_W-1:0] junk;
        settle_block();
        junk = $urandom;
        write_reg(cpg_pkg::REG_ANCHOR_GAP, {junk[cpg_pkg::DATA_W-1:cpg_pkg::GAP_W], 6'(gap)});
        junk = $urandom;
        write_reg(cpg_pkg::REG_ZONE_SIZE, {junk[cpg_pkg::DATA_W-1:cpg_pkg::ZONE_W], 4'(zone)});
    endtask

    task automatic send_random(input int count);
        repeat (count) send_cell(next_cell());
    endtask

    task automatic test_reset_defaults();
        peak_cell_t c;
        int i;
        for (i = 0; i < 14; i++)
        begin
            c.t = 32'hFFFF_FFF8 + i;
            case (i % 4)
                0: c.f = 10'h000;
                1: c.f = 10'h3FF;
                2: c.f = 10'h155;
                default: c.f = 10'h2AA;
            endcase
            send_cell(c);
        end
    endtask

    task automatic test_zero_gap();
        apply_config(0, 3);
        send_random(3);
    endtask

    task automatic test_zero_zone();
        apply_config(4, 0);
        send_random(2);
    endtask

    task automatic test_oversized_zone();
        apply_config(1, 15);
        send_random(2);
    endtask

    task automatic test_lookback_beyond_ring();
        apply_config(63, 2);
        send_random(2);
    endtask

    task automatic test_output_backpressure();
        apply_config(1, 8);
        long_hold_req = 1'b1;
        send_random(24);
        settle_block();
        send_random(6);
    endtask

    task automatic test_random_settings();
        int gaps [8] = '{48, 62, 1, 0, 5, 2, 30, 7};
        int zones [8] = '{8, 2, 1, 9, 4, 0, 3, 6};
        int p;
        idle_on = 1'b1;
        for (p = 0; p < 8; p++)
        begin
            apply_config(gaps[p], zones[p]);
            send_random(21);
        end
        for (p = 0; p < 3; p++)
        begin
            apply_config($urandom_range(0, 63), $urandom_range(0, 15));
            send_random(10);
        end
    endtask

    task automatic test_steady_stream();
        apply_config(2, 4);
        idle_on = 1'b0;
        send_random(30);
    endtask

    initial
    begin
        bit long_hold_done;
        pair_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                pair_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                pair_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 9)) @(posedge clk);
            end
            else
                pair_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pair_rec_t want;
        if (rst_n && pair_ch.valid && pair_ch.ready)
        begin
            if (pending_pairs.size() == 0)
            begin
                $error("unexpected pair record: anchor_time %h time_delta %h",
                       pair_ch.anchor_time, pair_ch.time_delta);
                failures++;
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (pair_ch.anchor_freq !== want.anchor_freq)
                begin
                    $error("anchor_freq: expected %h, got %h", want.anchor_freq,
                           pair_ch.anchor_freq);
                    failures++;
                end
                if (pair_ch.point_freq !== want.point_freq)
                begin
                    $error("point_freq: expected %h, got %h", want.point_freq,
                           pair_ch.point_freq);
                    failures++;
                end
                if (pair_ch.time_delta !== want.time_delta)
                begin
                    $error("time_delta: expected %h, got %h", want.time_delta,
                           pair_ch.time_delta);
                    failures++;
                end
                if (pair_ch.anchor_time !== want.anchor_time)
                begin
                    $error("anchor_time: expected %h, got %h", want.anchor_time,
                           pair_ch.anchor_time);
                    failures++;
                end
                if (pair_ch.last_in_zone !== want.last_in_zone)
                begin
                    $error("last_in_zone: expected %b, got %b", want.last_in_zone,
                           pair_ch.last_in_zone);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cell_ch.valid && cell_ch.ready) || (pair_ch.valid && pair_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cell_ch.valid = 1'b0;
        cell_ch.cell_time = '0;
        cell_ch.cell_freq = '0;
        ring_wr = '0;
        ring_fill = 0;
        gap_reg = cpg_pkg::ANCHOR_GAP_RESET;
        zone_reg = cpg_pkg::ZONE_SIZE_RESET;
        stream_time = $urandom;
        idle_on = 1'b1;
        long_hold_req = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_gap();
        test_zero_zone();
        test_oversized_zone();
        test_lookback_beyond_ring();
        test_output_backpressure();
        test_random_settings();
        test_steady_stream();

        settle_block();
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
sv/cpg_pkg.sv
sv/cpg_if.sv
sv/constellation_pair_generator.sv
sim/constellation_pair_generator_tb.sv
